// ===== sv/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

    // Command codes carried by a request beat. Code 7 has no meaning and is
    // answered as a no-operation.
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_DUMP_FWD   = 3'd5,
        CMD_DUMP_REV   = 3'd6
    } deq_cmd_t;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [3:0]         position;
        logic [4:0]         count;
        logic               last_of_run;
    } out_beat_t;

    // Datapath operations issued by the controller.
    typedef enum logic [1:0] {
        DP_NOP,
        DP_EXEC,
        DP_DUMP_FIRST,
        DP_DUMP_NEXT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   dump_rev;
    } deq_ctrl_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic dump_last;
    } deq_status_t;

endpackage

`default_nettype wire

// ===== sv/deq_datapath.sv =====
`default_nettype none

module deq_datapath
    import deq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_beat_t    req_beat,
    input  wire deq_ctrl_t   ctrl,
    output deq_status_t      status,
    input  wire logic        rsp_stall,
    output logic             rsp_valid,
    output out_beat_t        rsp_beat
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0]   CAP_S    = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
    localparam logic [SW-1:0] LAST_IDX = SW'(CAPACITY - 1);

    logic [SW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic          rev_reg, rev_next;
    logic          rsp_valid_reg, rsp_valid_next;
    out_beat_t     rsp_beat_reg, rsp_beat_next;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_data_reg;

    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          load;
    logic          full;
    logic          empty;
    logic          dump_last;
    out_beat_t     res;

    // Physical slot of the element a given offset behind the front.
    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        begin
            s = (CW + 1)'(base) + (CW + 1)'(off);
            if (s >= CAP_S)
            begin
                s = s - CAP_S;
            end
            return s[SW-1:0];
        end
    endfunction

    assign full      = (count_reg == CAP_C);
    assign empty     = (count_reg == '0);
    assign dump_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign status.out_free  = !rsp_valid_reg || !rsp_stall;
    assign status.empty     = empty;
    assign status.dump_last = dump_last;

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        rev_next   = rev_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        load       = 1'b0;
        res        = '0;

        case (ctrl.op)
            DP_EXEC:
            begin
                load            = 1'b1;
                res.last_of_run = 1'b1;
                res.status      = ST_OK;
                case (req_beat.cmd)
                    CMD_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            res.status = ST_FULL;
                        end
                        else
                        begin
                            front_next = (front_reg == '0) ? LAST_IDX
                                                           : front_reg - 1'b1;
                            wr_en      = 1'b1;
                            wr_addr    = front_next;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            res.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = slot_of(front_reg, count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            res.status = ST_EMPTY;
                        end
                        else
                        begin
                            front_next = slot_of(front_reg, CW'(1));
                            count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (empty)
                        begin
                            res.status = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        front_next = '0;
                        count_next = '0;
                    end
                    CMD_DUMP_FWD, CMD_DUMP_REV:
                    begin
                        if (empty)
                        begin
                            res.status = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        res.status = ST_OK;
                    end
                endcase
                res.count = 5'(count_next);
            end
            DP_DUMP_FIRST:
            begin
                rev_next = ctrl.dump_rev;
                idx_next = '0;
                rd_en    = 1'b1;
                rd_addr  = slot_of(front_reg, ctrl.dump_rev ? count_reg - 1'b1 : '0);
            end
            DP_DUMP_NEXT:
            begin
                load            = 1'b1;
                res.status      = ST_OK;
                res.element     = rd_data_reg;
                res.position    = 4'(idx_reg);
                res.count       = 5'(count_reg);
                res.last_of_run = dump_last;
                idx_next        = idx_reg + 1'b1;
                if (!dump_last)
                begin
                    rd_en   = 1'b1;
                    rd_addr = slot_of(front_reg,
                                      rev_reg ? count_reg - CW'(2) - CW'(idx_reg)
                                              : CW'(idx_reg) + CW'(1));
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        rsp_beat_next = load ? res : rsp_beat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rev_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rev_reg       <= rev_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_beat_reg <= rsp_beat_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req_beat.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("element count exceeds capacity");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(front_reg) < CAP_S)
        else $error("front slot out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !load)
        else $error("held result overwritten while stalled");

endmodule

`default_nettype wire

// ===== sv/deq_ctrl.sv =====
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic [2:0]  req_cmd,
    output logic             req_stall,
    input  wire deq_status_t status,
    output deq_ctrl_t        ctrl
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t state_reg, state_next;
    logic   is_dump;

    assign is_dump = (req_cmd == CMD_DUMP_FWD) || (req_cmd == CMD_DUMP_REV);

    always_comb
    begin
        state_next    = state_reg;
        req_stall     = 1'b1;
        ctrl.op       = DP_NOP;
        ctrl.dump_rev = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_stall = !status.out_free;
                if (req_valid && status.out_free)
                begin
                    if (is_dump && !status.empty)
                    begin
                        ctrl.op       = DP_DUMP_FIRST;
                        ctrl.dump_rev = (req_cmd == CMD_DUMP_REV);
                        state_next    = S_DUMP;
                    end
                    else
                    begin
                        ctrl.op = DP_EXEC;
                    end
                end
            end
            S_DUMP:
            begin
                if (status.out_free)
                begin
                    ctrl.op = DP_DUMP_NEXT;
                    if (status.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> !status.empty)
        else $error("dump in progress on an empty deque");

endmodule

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit elements in a circular buffer.
// Request channel (req_valid, req_stall, req_beat): each beat carries a command
// (push front or back, pop front or back, clear, dump forward or reverse) and
// a value used by the pushes. Response channel (rsp_valid, rsp_stall,
// rsp_beat): status, dumped element, position, element count, last flag.
// Push, pop, clear, an undefined command and a dump of an empty deque give
// one response beat, in the cycle after the request is accepted; such
// requests are taken at one per cycle while the receiver keeps up, since
// the response register frees as it is emptied.
// A dump of n elements gives n beats through the read data register and the
// response register, one per cycle while the receiver keeps up, paced by the
// single registered read port of the element store. Requests are stalled until
// the last dump beat has been loaded. When the receiver stalls, the response
// register holds its beat and the request side stalls as soon as a new result
// would have to be loaded. Reset empties the deque and the response register;
// element contents are not cleared, as only written slots are ever read.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire in_beat_t req_beat,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output out_beat_t     rsp_beat
);

    // Commands flow from the controller to the datapath; the datapath reports
    // whether the response register can take a beat, whether the deque is
    // empty, and whether the current dump beat is the final one.
    deq_ctrl_t   ctrl;
    deq_status_t status;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req_beat.cmd),
        .req_stall (req_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    deq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_beat  (req_beat),
        .ctrl      (ctrl),
        .status    (status),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_beat  (rsp_beat)
    );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

// Self-checking bench for the double-ended queue. Request beats are sent by
// one shared task, which also feeds each accepted beat to a behavioural
// model of the deque. The model queues the response beats that the block
// should produce. A separate process takes every accepted response beat and
// compares it, field by field, with the oldest beat still awaited.
module tb_top
    import deq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built at its default size, and the model uses the same depth.
    localparam int unsigned DEPTH = 16;
    localparam int unsigned SLOT_BITS = $clog2(DEPTH);

    // Command code 7 has no meaning. The block must answer it as a no-operation.
    localparam logic [2:0] CMD_UNDEFINED = 3'd7;

    // The watchdog allows this many cycles in which neither channel moves a beat.
    localparam int unsigned STALL_LIMIT = 4000;

    // These cycles let a late or stray response show itself after the last
    // awaited beat has arrived.
    localparam int unsigned SETTLE_CYCLES = 40;

    localparam int unsigned REPORT_LIMIT = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_beat_t  req_beat  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_beat_t rsp_beat;

    // These percentages set the idling. gap_pct is the chance that the sender
    // leaves a cycle empty before a beat. stall_pct is the chance that the
    // receiver stalls in any given cycle.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    // This is the model's own copy of the deque: the circular store, the slot
    // of the front element and the number of elements held.
    logic signed [31:0] model_slots [DEPTH];
    int unsigned        head_slot = 0;
    int unsigned        held      = 0;

    out_beat_t   awaited_beats [$];
    out_beat_t   oldest_beat;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    double_ended_queue #(
        .CAPACITY (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat)
    );

    always #6 clk = ~clk;

    // This task queues one awaited response beat. The count field always
    // carries the number of elements held after the operation.
    task automatic await_beat(input logic [1:0] status, input logic signed [31:0] element,
                              input int unsigned position, input bit last);
        out_beat_t beat;
        beat.status      = status;
        beat.element     = element;
        beat.position    = 4'(position);
        beat.count       = 5'(held);
        beat.last_of_run = last;
        awaited_beats = {awaited_beats, beat};
    endtask

    // This task applies one accepted request beat to the model and queues every
    // response beat that it causes. A push when full, a pop when empty and a
    // dump when empty leave the state alone and give one beat that carries the
    // status. A dump of a non-empty deque gives one beat per element held.
    task automatic model_request(input in_beat_t beat);
        int unsigned n;
        int unsigned offset;
        case (beat.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (held >= DEPTH)
                begin
                    await_beat(ST_FULL, '0, 0, 1'b1);
                end
                else
                begin
                    if (beat.cmd == CMD_PUSH_FRONT)
                    begin
                        head_slot = (head_slot + DEPTH - 1) % DEPTH;
                        model_slots[SLOT_BITS'(head_slot)] = beat.value;
                    end
                    else
                    begin
                        model_slots[SLOT_BITS'((head_slot + held) % DEPTH)] = beat.value;
                    end
                    held++;
                    await_beat(ST_OK, '0, 0, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (held == 0)
                begin
                    await_beat(ST_EMPTY, '0, 0, 1'b1);
                end
                else
                begin
                    // A pop from the back only shortens the deque. A pop from the
                    // front also moves the front slot on by one.
                    if (beat.cmd == CMD_POP_FRONT)
                    begin
                        head_slot = (head_slot + 1) % DEPTH;
                    end
                    held--;
                    await_beat(ST_OK, '0, 0, 1'b1);
                end
            end
            CMD_CLEAR:
            begin
                head_slot = 0;
                held      = 0;
                await_beat(ST_OK, '0, 0, 1'b1);
            end
            CMD_DUMP_FWD, CMD_DUMP_REV:
            begin
                if (held == 0)
                begin
                    await_beat(ST_EMPTY, '0, 0, 1'b1);
                end
                else
                begin
                    for (n = 0; n < held; n++)
                    begin
                        offset = (beat.cmd == CMD_DUMP_FWD) ? n : held - 1 - n;
                        await_beat(ST_OK,
                                   model_slots[SLOT_BITS'((head_slot + offset) % DEPTH)],
                                   n, n + 1 == held);
                    end
                end
            end
            default:
            begin
                await_beat(ST_OK, '0, 0, 1'b1);
            end
        endcase
    endtask

    // This task sends one request beat. It may first leave some idle cycles,
    // then waits for the handshake and hands the beat to the model. Valid stays
    // high after the handshake, so beats sent back to back need no dead cycle.
    // The payload changes only once the block has taken the previous beat.
    task automatic send_command(input logic [2:0] cmd, input logic signed [31:0] value);
        in_beat_t beat;
        beat.cmd   = cmd;
        beat.value = value;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= beat;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        model_request(beat);
    endtask

    // This function returns a value to push. Most values are uniform over 32 bits,
    // and now and then the largest, the smallest, zero or minus one is returned.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Every pop and dump on an empty deque must report empty, while clear
    // is always fine. Code 7 must come back as a plain no-operation.
    task automatic test_empty_deque();
        send_command(CMD_POP_FRONT, 32'sh1234_5678);
        send_command(CMD_POP_BACK, '1);
        send_command(CMD_DUMP_FWD, '0);
        send_command(CMD_DUMP_REV, 32'sh8000_0000);
        send_command(CMD_CLEAR, '0);
        send_command(CMD_UNDEFINED, 32'sh7FFF_FFFF);
    endtask

    // The extreme values are pushed at both ends, read back in both orders and
    // then one is popped from each end. After that the deque is cleared and dumped,
    // and the dump must see it empty.
    task automatic test_extreme_values();
        send_command(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_command(CMD_PUSH_BACK, 32'sh8000_0000);
        send_command(CMD_PUSH_FRONT, '0);
        send_command(CMD_PUSH_BACK, '1);
        send_command(CMD_DUMP_FWD, '0);
        send_command(CMD_DUMP_REV, '0);
        send_command(CMD_UNDEFINED, '1);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_POP_BACK, '0);
        send_command(CMD_CLEAR, '0);
        send_command(CMD_DUMP_FWD, '0);
    endtask

    // The deque is filled from both ends, so that the front slot wraps below
    // zero. A push at either end must then be refused as full, and dumps of
    // the full deque give the longest runs of beats.
    task automatic test_full_deque();
        int unsigned k;
        for (k = 0; k < DEPTH; k++)
        begin
            send_command(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        end
        send_command(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_command(CMD_PUSH_BACK, 32'sh8000_0000);
        send_command(CMD_DUMP_FWD, '0);
        send_command(CMD_DUMP_REV, '0);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_POP_BACK, '0);
        send_command(CMD_CLEAR, '0);
    endtask

    // This task sends random traffic. The share of pushes changes every 25
    // beats, so the fill level drifts between empty and full and both
    // boundaries are met many times over. Pushes, pops and dumps make up nearly
    // all of it. Clears and code 7 are rare, and the value field carries
    // random bits even on commands that ignore it.
    task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct,
                                      input int unsigned hold_pct);
        int unsigned k;
        int unsigned pick;
        int unsigned push_pct;
        logic [2:0]  cmd;
        gap_pct   = idle_pct;
        stall_pct = hold_pct;
        push_pct  = 50;
        for (k = 0; k < items; k++)
        begin
            if (k % 25 == 0)
            begin
                push_pct = $urandom_range(30, 70);
            end
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
            begin
                cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            end
            else if (pick < 80)
            begin
                cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
            end
            else if (pick < 82)
            begin
                cmd = CMD_CLEAR;
            end
            else if (pick < 98)
            begin
                cmd = $urandom_range(0, 1) ? CMD_DUMP_FWD : CMD_DUMP_REV;
            end
            else
            begin
                cmd = CMD_UNDEFINED;
            end
            send_command(cmd, pick_value());
        end
    endtask

    // The receiver stalls at random. The stall is registered at the clock edge
    // like every other input, so the checker below always sees its value from
    // before the edge.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // This process checks each accepted response beat against the oldest
    // awaited beat. A beat with nothing awaited is a failure too. Only the
    // first few failures are printed, and the rest are counted.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_beats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("%0t: response beat with none awaited: status=%0d element=%0d "
                             , $realtime, rsp_beat.status, rsp_beat.element,
                             "position=%0d count=%0d last=%0b", rsp_beat.position,
                             rsp_beat.count, rsp_beat.last_of_run);
                end
            end
            else
            begin
                oldest_beat = awaited_beats[0];
                awaited_beats.delete(0);
                if (rsp_beat.status !== oldest_beat.status
                    || rsp_beat.element !== oldest_beat.element
                    || rsp_beat.position !== oldest_beat.position
                    || rsp_beat.count !== oldest_beat.count
                    || rsp_beat.last_of_run !== oldest_beat.last_of_run)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: mismatch, expected status=%0d element=%0d position=%0d",
                                 $realtime, oldest_beat.status, oldest_beat.element,
                                 oldest_beat.position, " count=%0d last=%0b",
                                 oldest_beat.count, oldest_beat.last_of_run);
                        $display("%0t:           got status=%0d element=%0d position=%0d",
                                 $realtime, rsp_beat.status, rsp_beat.element,
                                 rsp_beat.position, " count=%0d last=%0b",
                                 rsp_beat.count, rsp_beat.last_of_run);
                    end
                end
            end
        end
    end

    // The watchdog ends the run once neither channel has moved a beat for too
    // long. Such a long pause means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The main sequence runs in this order. Reset is applied once. The directed
    // tests run next, under the first idling pattern. Random traffic then runs
    // in three phases. In the first, the sender is seldom idle and the receiver
    // stalls often. In the second the two are swapped, and in the third neither
    // side idles. At the end the bench drains every awaited beat and waits a
    // little longer for strays before giving the verdict.
    initial
    begin
        gap_pct   = 12;
        stall_pct = 71;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_deque();
        test_extreme_values();
        test_full_deque();
        test_random_traffic(104, 12, 71);
        test_random_traffic(103, 71, 12);
        test_random_traffic(103, 0, 0);
        req_valid <= 1'b0;

        while (awaited_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_beats.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
